// ===== hdl/bar_pkg.sv =====
`timescale 1ns / 1ps
package bar_pkg;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    typedef enum logic [1:0] {
        REG_CAL_A = 2'd0,
        REG_CAL_B = 2'd1,
        REG_CAL_C = 2'd2
    } t_reg_idx;

    // datapath widths
    localparam int UT_W    = 16;
    localparam int RAWP_W  = 24;
    localparam int UP_W    = 17;
    localparam int UP_SHIFT = 7;
    localparam int X1_W    = 19;
    localparam int T_W     = 16;
    localparam int P_W     = 18;

    // temperature divider: |MC * 2048| / |X1 + MD|
    localparam int TNUM_W  = 27;
    localparam int TDEN_W  = 20;
    localparam int TQUO_W  = 27;

    // pressure divider: |B7 or 2*B7| / |B4|, quotient bounded to 21 bits
    localparam int PNUM_W  = 64;
    localparam int PDEN_W  = 48;
    localparam int PQUO_W  = 21;

    localparam int B6_OFFSET  = 4000;
    localparam int B7_SCALE   = 25000;
    localparam int COR_SQ     = 3038;
    localparam int COR_LIN    = -7357;
    localparam int COR_OFS    = 3791;
    localparam int PRESS_MAX  = 262143;

    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic        [15:0] ac4;
        logic        [15:0] ac5;
        logic        [15:0] ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
    } t_cal;

    // travels alongside the temperature divider
    typedef struct packed {
        logic        [UP_W-1:0] up;
        logic signed [X1_W-1:0] x1;
        logic                   neg;
        logic                   fault;
    } t_tside;

    // travels alongside the pressure divider
    typedef struct packed {
        logic signed [T_W-1:0] t;
        logic                  neg;
        logic                  dbl;
        logic                  sat;
        logic                  fault;
    } t_pside;

endpackage

// ===== hdl/bar_cfg.sv =====
`timescale 1ns / 1ps
module bar_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bar_pkg::ADDR_W-1:0]    paddr,
    input  logic [bar_pkg::DATA_W-1:0]    pwdata,
    output logic [bar_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output bar_pkg::t_cal                 o_cal
);

    logic [63:0] r_cal_a;
    logic [63:0] r_cal_b;
    logic [31:0] r_cal_c;
    bar_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_idx  = bar_pkg::t_reg_idx'(paddr[4:3]);
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                bar_pkg::REG_CAL_A: r_cal_a <= pwdata;
                bar_pkg::REG_CAL_B: r_cal_b <= pwdata;
                bar_pkg::REG_CAL_C: r_cal_c <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            bar_pkg::REG_CAL_A: prdata = r_cal_a;
            bar_pkg::REG_CAL_B: prdata = r_cal_b;
            bar_pkg::REG_CAL_C: prdata = {32'd0, r_cal_c};
            default:            prdata = '0;
        endcase
    end

    assign o_cal = {r_cal_a, r_cal_b, r_cal_c};

endmodule

// ===== hdl/bar_tfront.sv =====
`timescale 1ns / 1ps
module bar_tfront (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [bar_pkg::UT_W-1:0]      i_ut,
    input  logic [bar_pkg::UP_W-1:0]      i_up,
    input  bar_pkg::t_cal                 i_cal,
    output logic                          o_valid,
    output logic [bar_pkg::TNUM_W-1:0]    o_num,
    output logic [bar_pkg::TDEN_W-1:0]    o_den,
    output bar_pkg::t_tside               o_side
);

    logic                    r_v1;
    logic signed [33:0]      r_prod;
    logic [bar_pkg::UP_W-1:0] r_up;

    logic signed [16:0]      w_diff;
    logic signed [18:0]      w_x1;
    logic signed [19:0]      w_den;
    logic [15:0]             w_mcmag;
    logic [19:0]             w_denmag;

    // UT - AC6, times AC5
    assign w_diff = signed'({1'b0, i_ut}) - signed'({1'b0, i_cal.ac6});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_diff * signed'({1'b0, i_cal.ac5});
            r_up   <= i_up;
        end
    end

    // X1 is the product shifted down by 15 (floor)
    assign w_x1     = r_prod[33:15];
    assign w_den    = 20'(w_x1) + 20'(i_cal.md);
    assign w_mcmag  = i_cal.mc[15] ? (~i_cal.mc + 16'd1) : i_cal.mc;
    assign w_denmag = w_den[19] ? (~w_den + 20'd1) : w_den;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num        <= {w_mcmag, 11'd0};
            o_den        <= w_denmag;
            o_side.up    <= r_up;
            o_side.x1    <= w_x1;
            o_side.neg   <= i_cal.mc[15] ^ w_den[19];
            o_side.fault <= (w_den == 20'sd0);
        end
    end

endmodule

// ===== hdl/bar_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage. The caller keeps
// i_num below i_den shifted up by QW.
module bar_div #(
    parameter int NW = 27,
    parameter int DW = 20,
    parameter int QW = 27,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    localparam int WW = NW + QW;

    logic          r_v    [QW];
    logic [NW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_q    [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic          w_vin;
        logic [NW-1:0] w_rin;
        logic [DW-1:0] w_din;
        logic [QW-1:0] w_qin;
        logic [SW-1:0] w_sin;
        logic [WW-1:0] w_sh;
        logic [WW:0]   w_tr;
        logic          w_ok;

        if (k == 0) begin : g_first
            assign w_vin = i_valid;
            assign w_rin = i_num;
            assign w_din = i_den;
            assign w_qin = '0;
            assign w_sin = i_side;
        end else begin : g_next
            assign w_vin = r_v[k-1];
            assign w_rin = r_rem[k-1];
            assign w_din = r_den[k-1];
            assign w_qin = r_q[k-1];
            assign w_sin = r_side[k-1];
        end

        assign w_sh = WW'(w_din) << B;
        assign w_tr = {1'b0, WW'(w_rin)} - {1'b0, w_sh};
        assign w_ok = ~w_tr[WW];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ok ? w_tr[NW-1:0] : w_rin;
                r_den[k]  <= w_din;
                r_q[k]    <= w_qin | (QW'(w_ok) << B);
                r_side[k] <= w_sin;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_q[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ===== hdl/bar_poly.sv =====
`timescale 1ns / 1ps
module bar_poly (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [bar_pkg::TQUO_W-1:0]    i_quo,
    input  bar_pkg::t_tside               i_side,
    input  bar_pkg::t_cal                 i_cal,
    output logic                          o_valid,
    output logic [bar_pkg::PNUM_W-1:0]    o_num,
    output logic [bar_pkg::PDEN_W-1:0]    o_den,
    output bar_pkg::t_pside               o_side
);

    localparam int NSTG = 10;
    localparam int CMP_W = bar_pkg::PDEN_W + bar_pkg::PQUO_W;

    logic [NSTG-1:0] r_v;

    logic signed [27:0] r1_b5;
    logic signed [27:0] r2_b6;
    logic signed [55:0] r3_sqf;
    logic signed [43:0] r3_m2, r3_m3;
    logic signed [60:0] r4_pb2, r4_pb1;
    logic signed [32:0] r4_m2s;
    logic signed [30:0] r4_m3s;
    logic signed [50:0] r5_x3a;
    logic signed [45:0] r5_sb;
    logic signed [51:0] r6_b3;
    logic signed [45:0] r6_x3c;
    logic signed [62:0] r7_prod4;
    logic signed [52:0] r7_diff;
    logic signed [47:0] r8_b4;
    logic signed [63:0] r8_b7;
    logic [63:0]        r9_num;
    logic [47:0]        r9_den;

    // carried fields, one copy per stage
    logic [bar_pkg::UP_W-1:0]   r_up  [6];
    logic                       r_flt [9];
    logic signed [15:0]         r_t   [2:9];
    logic                       r9_neg, r9_dbl;

    logic signed [27:0] w_q, w_x2, w_b5;
    logic signed [28:0] w_b5p;
    logic signed [24:0] w_tq;
    logic signed [15:0] w_t;
    logic signed [44:0] w_sq;
    logic signed [52:0] w_a;
    logic signed [46:0] w_sb2;
    logic               w_dbl;
    logic signed [63:0] w_num;
    logic [63:0]        w_nmag;
    logic [47:0]        w_dmag;
    logic               w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    // B5 = X1 + X2, with X2 the signed quotient
    assign w_q  = signed'({1'b0, i_quo});
    assign w_x2 = i_side.neg ? -w_q : w_q;
    assign w_b5 = 28'(i_side.x1) + w_x2;

    // temperature: (B5 + 8) >> 4, saturated
    assign w_b5p = 29'(r1_b5) + 29'sd8;
    assign w_tq  = w_b5p[28:4];
    always_comb begin
        priority if (w_tq > 25'sd32767) begin
            w_t = 16'sh7FFF;
        end else if (w_tq < -25'sd32768) begin
            w_t = 16'sh8000;
        end else begin
            w_t = w_tq[15:0];
        end
    end

    assign w_sq  = signed'({1'b0, r3_sqf[55:12]});
    assign w_a   = (53'(i_cal.ac1) <<< 2) + 53'(r5_x3a) + 53'sd1;
    assign w_sb2 = 47'(r5_sb) + 47'sd2;

    // pick the dividend form, then split into magnitudes and sign
    assign w_dbl  = (r8_b7 > 64'sh7FFFFFFF);
    assign w_num  = w_dbl ? r8_b7 : (r8_b7 <<< 1);
    assign w_nmag = w_num[63] ? (~w_num + 64'd1) : w_num;
    assign w_dmag = r8_b4[47] ? (~r8_b4 + 48'd1) : r8_b4;

    // quotient of 2^21 or more saturates the result either way
    assign w_sat = {{(CMP_W-bar_pkg::PNUM_W){1'b0}}, r9_num} >=
                   {r9_den, {bar_pkg::PQUO_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // P1
            r1_b5    <= w_b5;
            r_up[0]  <= i_side.up;
            r_flt[0] <= i_side.fault;
            // P2
            r2_b6    <= r1_b5 - 28'(bar_pkg::B6_OFFSET);
            r_t[2]   <= w_t;
            r_up[1]  <= r_up[0];
            r_flt[1] <= r_flt[0];
            // P3
            r3_sqf   <= r2_b6 * r2_b6;
            r3_m2    <= i_cal.ac2 * r2_b6;
            r3_m3    <= i_cal.ac3 * r2_b6;
            r_t[3]   <= r_t[2];
            r_up[2]  <= r_up[1];
            r_flt[2] <= r_flt[1];
            // P4
            r4_pb2   <= i_cal.b2 * w_sq;
            r4_pb1   <= i_cal.b1 * w_sq;
            r4_m2s   <= r3_m2[43:11];
            r4_m3s   <= r3_m3[43:13];
            r_t[4]   <= r_t[3];
            r_up[3]  <= r_up[2];
            r_flt[3] <= r_flt[2];
            // P5
            r5_x3a   <= 51'(signed'(r4_pb2[60:11])) + 51'(r4_m2s);
            r5_sb    <= 46'(signed'(r4_pb1[60:16])) + 46'(r4_m3s);
            r_t[5]   <= r_t[4];
            r_up[4]  <= r_up[3];
            r_flt[4] <= r_flt[3];
            // P6: B3 and X3 + 32768
            r6_b3    <= w_a[52:1];
            r6_x3c   <= 46'(signed'(w_sb2[46:2])) + 46'sd32768;
            r_t[6]   <= r_t[5];
            r_up[5]  <= r_up[4];
            r_flt[5] <= r_flt[4];
            // P7
            r7_prod4 <= signed'({1'b0, i_cal.ac4}) * r6_x3c;
            r7_diff  <= 53'(signed'({1'b0, r_up[5]})) - 53'(r6_b3);
            r_t[7]   <= r_t[6];
            r_flt[6] <= r_flt[5];
            // P8
            r8_b4    <= r7_prod4[62:15];
            r8_b7    <= r7_diff * 64'(bar_pkg::B7_SCALE);
            r_t[8]   <= r_t[7];
            r_flt[7] <= r_flt[6];
            // P9
            r9_num   <= w_nmag;
            r9_den   <= w_dmag;
            r9_neg   <= w_num[63] ^ r8_b4[47];
            r9_dbl   <= w_dbl;
            r_t[9]   <= r_t[8];
            r_flt[8] <= r_flt[7] | (r8_b4 == 48'sd0);
            // P10
            o_num        <= (w_sat | r_flt[8]) ? '0 : r9_num;
            o_den        <= r9_den;
            o_side.t     <= r_t[9];
            o_side.neg   <= r9_neg;
            o_side.dbl   <= r9_dbl;
            o_side.sat   <= w_sat;
            o_side.fault <= r_flt[8];
        end
    end

    assign o_valid = r_v[NSTG-1];

endmodule

// ===== hdl/bar_corr.sv =====
`timescale 1ns / 1ps
module bar_corr (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [bar_pkg::PQUO_W-1:0]    i_quo,
    input  bar_pkg::t_pside               i_side,
    output logic                          o_valid,
    output logic signed [bar_pkg::T_W-1:0] o_t,
    output logic [bar_pkg::P_W-1:0]       o_p,
    output logic                          o_fault
);

    localparam int NSTG = 4;

    logic [NSTG-1:0]    r_v;
    logic [19:0]        r_p    [1:3];
    logic               r_zero [1:3];
    logic               r_max  [1:3];
    logic               r_flt  [1:3];
    logic signed [15:0] r_t    [1:3];
    logic [23:0]        r2_pp;
    logic signed [34:0] r2_mp;
    logic [19:0]        r3_x1;
    logic signed [18:0] r3_x2;

    logic [21:0]        w_pm;
    logic               w_zero;
    logic [35:0]        w_x1f;
    logic signed [22:0] w_cs;
    logic signed [18:0] w_cor;
    logic signed [22:0] w_pf;
    logic [17:0]        w_pcl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    // magnitude of p; a negative nonzero p goes to zero, a large one to full scale
    assign w_pm   = i_side.dbl ? {i_quo, 1'b0} : {1'b0, i_quo};
    assign w_zero = i_side.fault | (i_side.neg & (i_side.sat | (w_pm != 22'd0)));

    assign w_x1f = r2_pp * 36'(bar_pkg::COR_SQ);
    assign w_cs  = 23'(signed'({1'b0, r3_x1})) + 23'(r3_x2) + 23'(bar_pkg::COR_OFS);
    assign w_cor = w_cs[22:4];
    assign w_pf  = 23'(signed'({1'b0, r_p[3]})) + 23'(w_cor);

    always_comb begin
        priority if (w_pf < 23'sd0) begin
            w_pcl = '0;
        end else if (w_pf > 23'(bar_pkg::PRESS_MAX)) begin
            w_pcl = 18'(bar_pkg::PRESS_MAX);
        end else begin
            w_pcl = w_pf[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // C1
            r_p[1]    <= w_pm[19:0];
            r_zero[1] <= w_zero;
            r_max[1]  <= ~w_zero & (i_side.sat | (w_pm[21:20] != 2'd0));
            r_flt[1]  <= i_side.fault;
            r_t[1]    <= i_side.t;
            // C2: (p >> 8)^2 and -7357 * p
            r2_pp     <= r_p[1][19:8] * r_p[1][19:8];
            r2_mp     <= signed'({1'b0, r_p[1]}) * 35'(bar_pkg::COR_LIN);
            r_p[2]    <= r_p[1];
            r_zero[2] <= r_zero[1];
            r_max[2]  <= r_max[1];
            r_flt[2]  <= r_flt[1];
            r_t[2]    <= r_t[1];
            // C3
            r3_x1     <= w_x1f[35:16];
            r3_x2     <= r2_mp[34:16];
            r_p[3]    <= r_p[2];
            r_zero[3] <= r_zero[2];
            r_max[3]  <= r_max[2];
            r_flt[3]  <= r_flt[2];
            r_t[3]    <= r_t[2];
            // C4
            o_t       <= r_flt[3] ? '0 : r_t[3];
            o_fault   <= r_flt[3];
            if (r_zero[3]) begin
                o_p <= '0;
            end else if (r_max[3]) begin
                o_p <= 18'(bar_pkg::PRESS_MAX);
            end else begin
                o_p <= w_pcl;
            end
        end
    end

    assign o_valid = r_v[NSTG-1];

endmodule

// ===== hdl/barometer_compensation.sv =====
`timescale 1ns / 1ps
// Channel     Dir  Signals                          Content
// s_axis      in   tvalid tready tdata[39:0]        raw temperature, raw pressure
// m_axis      out  tvalid tready tdata[39:0] tuser  temperature, pressure; divide fault
// apb         in   psel penable pwrite paddr pwdata cal words A, B, C at 0x00, 0x08, 0x10
//
// One reading per clock while the skid register is empty. A reading passes 2 front
// stages, 27 temperature divider stages, 10 polynomial stages, 21 pressure divider
// stages, 4 correction stages and the output register on its way to m_axis.
// Reset is synchronous and active low; it clears all valid bits and the calibration.
// A stalled output holds; one more result lands in the skid register, then the
// whole pipeline freezes and s_axis_tready drops until the skid drains.
module barometer_compensation (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [39:0]                 s_axis_tdata,   // raw_temperature[15:0], raw_pressure[39:16]
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [39:0]                 m_axis_tdata,   // temperature_tenths[15:0], pressure_pa[33:16], zero
    output logic                        m_axis_tuser,   // divide_fault[0]
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bar_pkg::ADDR_W-1:0]  paddr,
    input  logic [bar_pkg::DATA_W-1:0]  pwdata,
    output logic [bar_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    bar_pkg::t_cal   w_cal;
    logic            w_en;

    logic                         w_tf_valid;
    logic [bar_pkg::TNUM_W-1:0]   w_tf_num;
    logic [bar_pkg::TDEN_W-1:0]   w_tf_den;
    bar_pkg::t_tside              w_tf_side;

    logic                         w_td_valid;
    logic [bar_pkg::TQUO_W-1:0]   w_td_quo;
    bar_pkg::t_tside              w_td_side;

    logic                         w_po_valid;
    logic [bar_pkg::PNUM_W-1:0]   w_po_num;
    logic [bar_pkg::PDEN_W-1:0]   w_po_den;
    bar_pkg::t_pside              w_po_side;

    logic                         w_pd_valid;
    logic [bar_pkg::PQUO_W-1:0]   w_pd_quo;
    bar_pkg::t_pside              w_pd_side;

    logic                         w_co_valid;
    logic signed [bar_pkg::T_W-1:0] w_co_t;
    logic [bar_pkg::P_W-1:0]      w_co_p;
    logic                         w_co_fault;

    // output register and skid register
    logic                         r_out_valid;
    logic signed [bar_pkg::T_W-1:0] r_out_t;
    logic [bar_pkg::P_W-1:0]      r_out_p;
    logic                         r_out_fault;
    logic                         r_skid_valid;
    logic signed [bar_pkg::T_W-1:0] r_skid_t;
    logic [bar_pkg::P_W-1:0]      r_skid_p;
    logic                         r_skid_fault;
    logic                         w_take;
    logic                         w_out_free;

    // the pipeline advances as long as the skid register is empty
    assign w_en          = ~r_skid_valid;
    assign s_axis_tready = w_en;

    bar_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cal   (w_cal)
    );

    // X1 and the operands of the temperature division
    bar_tfront u_tfront (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_ut    (s_axis_tdata[15:0]),
        .i_up    (s_axis_tdata[39:16+bar_pkg::UP_SHIFT]),
        .i_cal   (w_cal),
        .o_valid (w_tf_valid),
        .o_num   (w_tf_num),
        .o_den   (w_tf_den),
        .o_side  (w_tf_side)
    );

    bar_div #(
        .NW (bar_pkg::TNUM_W),
        .DW (bar_pkg::TDEN_W),
        .QW (bar_pkg::TQUO_W),
        .SW ($bits(bar_pkg::t_tside))
    ) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_tf_valid),
        .i_num   (w_tf_num),
        .i_den   (w_tf_den),
        .i_side  (w_tf_side),
        .o_valid (w_td_valid),
        .o_quo   (w_td_quo),
        .o_side  (w_td_side)
    );

    // B5, temperature, B3, B4, B7 and the operands of the pressure division
    bar_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_td_valid),
        .i_quo   (w_td_quo),
        .i_side  (w_td_side),
        .i_cal   (w_cal),
        .o_valid (w_po_valid),
        .o_num   (w_po_num),
        .o_den   (w_po_den),
        .o_side  (w_po_side)
    );

    bar_div #(
        .NW (bar_pkg::PNUM_W),
        .DW (bar_pkg::PDEN_W),
        .QW (bar_pkg::PQUO_W),
        .SW ($bits(bar_pkg::t_pside))
    ) u_pdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_po_valid),
        .i_num   (w_po_num),
        .i_den   (w_po_den),
        .i_side  (w_po_side),
        .o_valid (w_pd_valid),
        .o_quo   (w_pd_quo),
        .o_side  (w_pd_side)
    );

    // final pressure correction, clamping and fault zeroing
    bar_corr u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_pd_valid),
        .i_quo   (w_pd_quo),
        .i_side  (w_pd_side),
        .o_valid (w_co_valid),
        .o_t     (w_co_t),
        .o_p     (w_co_p),
        .o_fault (w_co_fault)
    );

    assign w_take     = r_out_valid & m_axis_tready;
    assign w_out_free = ~r_out_valid | w_take;

    // Output side: a result leaving the pipeline goes to the output register when
    // that is free, else to the skid register. The skid refills the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_co_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= ~w_out_free;
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out_t     <= r_skid_t;
                r_out_p     <= r_skid_p;
                r_out_fault <= r_skid_fault;
            end
        end else if (w_co_valid) begin
            if (w_out_free) begin
                r_out_t     <= w_co_t;
                r_out_p     <= w_co_p;
                r_out_fault <= w_co_fault;
            end else begin
                r_skid_t     <= w_co_t;
                r_skid_p     <= w_co_p;
                r_skid_fault <= w_co_fault;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_p, r_out_t};
    assign m_axis_tuser  = r_out_fault;

endmodule

// ===== tb/barometer_compensation_test.sv =====
`timescale 1ns / 1ps
module barometer_compensation_test;

    typedef struct packed {
        logic signed [15:0] temp;
        logic        [17:0] press;
        logic               fault;
    } t_reading_out;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [39:0]       m_axis_tdata;
    logic              m_axis_tuser;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [bar_pkg::ADDR_W-1:0] paddr;
    logic [bar_pkg::DATA_W-1:0] pwdata;
    logic [bar_pkg::DATA_W-1:0] prdata;
    logic              pready;

    // local copy of the calibration words
    logic [63:0] cal_a_copy;
    logic [63:0] cal_b_copy;
    logic [31:0] cal_c_copy;

    t_reading_out pending_readings[$];
    int  mismatches;
    bit  calm_sink;
    bit  calm_source;

    localparam logic [63:0] TYP_A = {16'sd408, -16'sd72, -16'sd14383, 16'd32741};
    localparam logic [63:0] TYP_B = {16'd32757, 16'd23153, 16'sd6190, 16'sd4};
    localparam logic [31:0] TYP_C = {-16'sd8711, 16'sd2868};

    barometer_compensation uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Sign-extend a 16-bit calibration field.
    function automatic longint sx16(logic [15:0] v);
        return longint'(signed'(v));
    endfunction

    // Integer compensation of one reading against the current calibration.
    // >>> on longint floors, / truncates toward zero.
    function automatic t_reading_out compensate(logic [15:0] ut_raw, logic [23:0] p_raw);
        t_reading_out r;
        longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
        longint x1, x2, x3, b3, b4, b5, b6, b7, sq, p, t, den;
        ac1 = sx16(cal_a_copy[63:48]);
        ac2 = sx16(cal_a_copy[47:32]);
        ac3 = sx16(cal_a_copy[31:16]);
        ac4 = longint'(cal_a_copy[15:0]);
        ac5 = longint'(cal_b_copy[63:48]);
        ac6 = longint'(cal_b_copy[47:32]);
        b1  = sx16(cal_b_copy[31:16]);
        b2  = sx16(cal_b_copy[15:0]);
        mc  = sx16(cal_c_copy[31:16]);
        md  = sx16(cal_c_copy[15:0]);
        ut  = longint'(ut_raw);
        up  = longint'(p_raw >> 7);
        r = '0;
        x1 = ((ut - ac6) * ac5) >>> 15;
        den = x1 + md;
        if (den == 0) begin
            r.fault = 1'b1;
            return r;
        end
        x2 = (mc * 2048) / den;
        b5 = x1 + x2;
        b6 = b5 - 4000;
        sq = (b6 * b6) >>> 12;
        x3 = ((b2 * sq) >>> 11) + ((ac2 * b6) >>> 11);
        b3 = ((ac1 * 4 + x3) * 2 + 2) >>> 2;
        x3 = (((ac3 * b6) >>> 13) + ((b1 * sq) >>> 16) + 2) >>> 2;
        b4 = (ac4 * (x3 + 32768)) >>> 15;
        if (b4 == 0) begin
            r.fault = 1'b1;
            return r;
        end
        t = (b5 + 8) >>> 4;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        r.temp = t[15:0];
        b7 = (up - b3) * 25000;
        if (b7 < 64'sd2147483648) p = (b7 * 2) / b4;
        else p = (b7 / b4) * 2;
        if (p < 0) begin
            r.press = '0;
        end else if (p >= 1048576) begin
            r.press = 18'h3FFFF;
        end else begin
            x1 = (p >>> 8) * (p >>> 8);
            x1 = (x1 * 3038) >>> 16;
            x2 = (-7357 * p) >>> 16;
            p = p + ((x1 + x2 + 3791) >>> 4);
            if (p < 0) p = 0;
            if (p > bar_pkg::PRESS_MAX) p = bar_pkg::PRESS_MAX;
            r.press = p[17:0];
        end
        return r;
    endfunction

    // Sink: randomly stall, check each result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_reading_out want;
        if (i_rst_n) begin
            m_axis_tready <= calm_sink || ($urandom_range(99) >= 14);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_readings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result tdata=%h tuser=%b",
                                 m_axis_tdata, m_axis_tuser);
                end else begin
                    want = pending_readings.pop_front();
                    if (m_axis_tdata[15:0] !== want.temp ||
                        m_axis_tdata[33:16] !== want.press ||
                        m_axis_tdata[39:34] !== 6'd0 ||
                        m_axis_tuser !== want.fault) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp t=%0d p=%0d f=%b, got t=%0d p=%0d f=%b pad=%h",
                                     want.temp, want.press, want.fault,
                                     $signed(m_axis_tdata[15:0]), m_axis_tdata[33:16],
                                     m_axis_tuser, m_axis_tdata[39:34]);
                    end
                end
            end
        end
    end

    // Write one calibration register over APB; index 3 is outside the map.
    task automatic write_cal(int idx, logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bar_pkg::ADDR_W'(idx * 8);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bar_pkg::REG_CAL_A: cal_a_copy = value;
            bar_pkg::REG_CAL_B: cal_b_copy = value;
            bar_pkg::REG_CAL_C: cal_c_copy = value[31:0];
            default: ;
        endcase
    endtask

    // Let every reading in flight land before the calibration changes.
    task automatic load_cal(logic [63:0] a, logic [63:0] b, logic [63:0] c);
        drain_pipe();
        write_cal(bar_pkg::REG_CAL_A, a);
        write_cal(bar_pkg::REG_CAL_B, b);
        write_cal(bar_pkg::REG_CAL_C, c);
    endtask

    // Offer one reading; hold tvalid high afterwards so back-to-back transfers stream.
    task automatic send_reading(logic [15:0] ut, logic [23:0] rp);
        if (!calm_source && $urandom_range(99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rp, ut};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_readings.push_back(compensate(ut, rp));
    endtask

    // Stop sending, let every prediction land, then give the pipe its latency.
    task automatic drain_pipe();
        int guard;
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (pending_readings.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (70) @(posedge i_clk);
    endtask

    // Calibration still at reset: zero divisor on every reading.
    task automatic test_reset_calibration();
        send_reading(16'h0000, 24'h000000);
        send_reading(16'hFFFF, 24'hFFFFFF);
        send_reading(16'h5A5A, 24'hA5A5A5);
        drain_pipe();
    endtask

    // Typical coefficients with field extremes, low and high pressure.
    task automatic test_typical_extremes();
        load_cal(TYP_A, TYP_B, 64'hFFFF_FFFF_0000_0000 | TYP_C); // high bits ignored
        write_cal(3, 64'hFFFF_FFFF_FFFF_FFFF);                   // unmapped, ignored
        send_reading(16'd27898, 24'd23843 << 7);
        send_reading(16'h0000, 24'h000000);
        send_reading(16'hFFFF, 24'hFFFFFF);
        send_reading(16'h0000, 24'hFFFFFF);
        send_reading(16'hFFFF, 24'h000000);
        send_reading(16'd27898, 24'h00007F);
        send_reading(16'd30000, 24'h3FFFFF);
        drain_pipe();
    endtask

    // Zero divisor in each place, saturated temperature, very large pressure.
    task automatic test_special_cases();
        load_cal(TYP_A & ~64'hFFFF, TYP_B, TYP_C);          // AC4 = 0 gives B4 = 0
        send_reading(16'd27898, 24'd23843 << 7);
        load_cal(TYP_A, {16'd0, TYP_B[47:0]}, {16'sd32767, 16'sd0}); // X1 + MD = 0
        send_reading(16'd1234, 24'h123456);
        load_cal(TYP_A, {16'd0, TYP_B[47:0]}, {16'sd32767, 16'sd1});
        send_reading(16'd100, 24'h400000);
        load_cal(TYP_A, {16'd0, TYP_B[47:0]}, {-16'sd32768, 16'sd1});
        send_reading(16'd100, 24'h400000);
        load_cal({TYP_A[63:16], 16'd1}, TYP_B, TYP_C);       // tiny B4, huge pressure
        send_reading(16'd27898, 24'hFFFFFF);
        send_reading(16'd27898, 24'h000000);
        load_cal(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF);
        send_reading(16'hFFFF, 24'hFFFFFF);
        send_reading(16'h0000, 24'h000000);
        load_cal(64'h7FFF_7FFF_7FFF_FFFF, 64'hFFFF_0000_7FFF_7FFF, 32'h7FFF_7FFF);
        send_reading(16'hFFFF, 24'hFFFFFF);
        send_reading(16'h8000, 24'h800000);
        load_cal(64'h8000_8000_8000_0001, 64'h0001_FFFF_8000_8000, 32'h8000_8000);
        send_reading(16'h0000, 24'hFFFFFF);
        send_reading(16'h7FFF, 24'h7FFFFF);
        drain_pipe();
    endtask

    function automatic logic [15:0] nudge(logic [15:0] v, int spread);
        return v + 16'($urandom_range(2 * spread) - spread);
    endfunction

    // Random readings over several calibration sets, near-typical and arbitrary.
    task automatic test_random_sweep();
        logic [63:0] a, b;
        logic [31:0] c;
        logic [15:0] ut;
        logic [23:0] rp;
        for (int phase = 0; phase < 6; phase++) begin
            if (phase % 3 == 2) begin
                a = {$urandom, $urandom};
                b = {$urandom, $urandom};
                c = $urandom;
            end else begin
                a = {nudge(TYP_A[63:48], 300), nudge(TYP_A[47:32], 300),
                     nudge(TYP_A[31:16], 2000), nudge(TYP_A[15:0], 3000)};
                b = {nudge(TYP_B[63:48], 3000), nudge(TYP_B[47:32], 3000),
                     nudge(TYP_B[31:16], 1000), nudge(TYP_B[15:0], 50)};
                c = {nudge(TYP_C[31:16], 1500), nudge(TYP_C[15:0], 800)};
            end
            load_cal(a, b, {$urandom, c});
            calm_sink   = (phase == 1);
            calm_source = (phase == 1);
            for (int n = 0; n < 88; n++) begin
                if ($urandom_range(3) == 0) begin
                    ut = 16'($urandom);
                    rp = 24'($urandom);
                end else begin
                    ut = 16'($urandom_range(34000, 20000));
                    rp = 24'($urandom_range(26000, 17000) << 7) | 24'($urandom_range(127));
                end
                send_reading(ut, rp);
                // hold off mid-phase until every result has come back
                if (n == 40 && phase == 3) begin
                    s_axis_tvalid <= 1'b0;
                    while (pending_readings.size() != 0) @(posedge i_clk);
                end
            end
            drain_pipe();
            calm_sink   = 0;
            calm_source = 0;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cal_a_copy    = '0;
        cal_b_copy    = '0;
        cal_c_copy    = '0;
        mismatches    = 0;
        calm_sink     = 0;
        calm_source   = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_calibration();
        test_typical_extremes();
        test_special_cases();
        test_random_sweep();

        if (pending_readings.size() != 0) mismatches++;
        if (mismatches == 0)
            $display("barometer_compensation test passed");
        else
            $display("barometer_compensation test failed");
        $finish;
    end

    // Watchdog: generous fixed limit.
    initial begin
        #4000000;
        $display("barometer_compensation test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/bar_pkg.sv
hdl/bar_cfg.sv
hdl/bar_tfront.sv
hdl/bar_div.sv
hdl/bar_poly.sv
hdl/bar_corr.sv
hdl/barometer_compensation.sv
tb/barometer_compensation_test.sv
